// ===== hdl/shdf_pkg.sv =====
// Shared types and constants of the sync-header frame deframer.
// Used by the channel interfaces, the sync compare unit and the top level.
package shdf_pkg;

  localparam int unsigned HDR_BYTES = 9;
  // Header bytes held in registers; the final header byte is taken straight off the input.
  localparam int unsigned STORE_DEPTH = HDR_BYTES - 1;

  localparam logic [7:0] SYNC0 = 8'h42;
  localparam logic [7:0] SYNC1 = 8'h43;
  localparam logic [7:0] SYNC2 = 8'h32;

  localparam logic [7:0]  RST_VERSION = 8'd1;
  localparam logic [15:0] RST_MAX_LEN = 16'd512;

  typedef logic [7:0]  byte_t;
  typedef logic [3:0]  fill_t;
  typedef logic [15:0] len_t;

  typedef enum logic [1:0] {
    REG_CMD     = 2'd0,
    REG_SEQ     = 2'd1,
    REG_MAX_LEN = 2'd2,
    REG_VERSION = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_HUNT    = 5'b00001,
    S_HEADER  = 5'b00010,
    S_DELIVER = 5'b00100,
    S_SKIP    = 5'b01000,
    S_RESCAN  = 5'b10000
  } state_t;

  // Result of the sync compare unit on the front of a buffer view.
  typedef struct packed {
    logic sync_hit;    // three valid bytes that form the full sync word
    logic prefix_hit;  // fewer than three valid bytes that could still start it
  } sync_chk_t;

endpackage

// ===== hdl/shdf_rx_if.sv =====
// Input channel of the deframer: one received byte per transaction.
// Depends on shdf_pkg for the byte type.
interface shdf_rx_if;
  logic               valid;
  logic               ready;
  shdf_pkg::byte_t    rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/shdf_res_if.sv =====
// Result channel of the deframer: one payload byte or empty-frame marker per transaction.
// Depends on shdf_pkg for the byte type.
interface shdf_res_if;
  logic               valid;
  logic               ready;
  shdf_pkg::byte_t    payload_byte;
  logic               last;
  logic               empty_frame;

  modport source (output valid, output payload_byte, output last, output empty_frame,
                  input ready);
  modport sink   (input valid, input payload_byte, input last, input empty_frame,
                  output ready);
endinterface

// ===== hdl/sync_header_frame_deframer_core.sv =====
// Top level of the sync-header frame deframer: parse sequencer, header buffer, result register.
// Depends on shdf_pkg, shdf_rx_if, shdf_res_if and shdf_sync_cmp.
//
//   Channel   Direction  Payload                               Transaction when
//   in_ch     sink       rx_byte[7:0]                          valid && ready
//   out_ch    source     payload_byte[7:0], last, empty_frame  valid && ready
//   cfg_*     sink       cfg_index[1:0], cfg_wdata[15:0]       cfg_we
//
// in_ch accepts received bytes while hunting, collecting a header, delivering or
// skipping payload. A header rejected for version or length starts the rescan sequencer,
// which walks the eight remaining header bytes through the one sync compare unit, one
// byte position per cycle, with in_ch.ready low throughout.
// in_ch.ready is also low while a finished result waits in the output register and
// out_ch.ready is low. rst_n is synchronous and active low; it clears the parser and
// loads the register reset values. There is no clearing pass.
module sync_header_frame_deframer_core (
  input  logic                clk,
  input  logic                rst_n,
  shdf_rx_if.sink             in_ch,
  shdf_res_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import shdf_pkg::*;

  // Configuration registers.
  byte_t exp_cmd_r;
  len_t  exp_seq_r;
  len_t  max_len_r;
  byte_t version_r;

  // Parser state.
  state_t state_r, state_nxt;
  fill_t  fill_r, fill_nxt;
  len_t   rem_r, rem_nxt;
  byte_t  store_r   [STORE_DEPTH];
  byte_t  store_nxt [STORE_DEPTH];

  // Output register.
  logic  out_valid_r, out_valid_nxt;
  byte_t out_byte_r, out_byte_nxt;
  logic  out_last_r, out_last_nxt;
  logic  out_empty_r, out_empty_nxt;

  // Sync compare unit inputs and result.
  byte_t     cmp_b0, cmp_b1, cmp_b2;
  fill_t     cmp_fill;
  sync_chk_t chk;

  logic  accept;
  logic  out_free;
  byte_t rx;
  len_t  hdr_len, hdr_seq;
  logic  hdr_ok, hdr_match;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r != S_RESCAN) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign rx          = in_ch.rx_byte;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.payload_byte = out_byte_r;
  assign out_ch.last         = out_last_r;
  assign out_ch.empty_frame  = out_empty_r;

  // While hunting, the compare unit sees the buffered prefix with the new byte appended.
  // While rescanning, it sees the front of the buffer as it stands.
  always_comb begin
    if (state_r == S_HUNT) begin
      cmp_b0   = (fill_r == 4'd0) ? rx : store_r[0];
      cmp_b1   = (fill_r == 4'd1) ? rx : store_r[1];
      cmp_b2   = (fill_r == 4'd2) ? rx : store_r[2];
      cmp_fill = fill_r + 4'd1;
    end else begin
      cmp_b0   = store_r[0];
      cmp_b1   = store_r[1];
      cmp_b2   = store_r[2];
      cmp_fill = fill_r;
    end
  end

  shdf_sync_cmp u_sync_cmp (
    .b0   (cmp_b0),
    .b1   (cmp_b1),
    .b2   (cmp_b2),
    .fill (cmp_fill),
    .chk  (chk)
  );

  // Header fields when the final header byte arrives on the input.
  assign hdr_len   = {rx, store_r[7]};
  assign hdr_seq   = {store_r[6], store_r[5]};
  assign hdr_ok    = (store_r[3] == version_r) && (hdr_len <= max_len_r);
  assign hdr_match = (store_r[4] == exp_cmd_r) && (hdr_seq == exp_seq_r);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    rem_nxt       = rem_r;
    store_nxt     = store_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;

    unique case (state_r)
      S_HUNT: begin
        if (accept) begin
          if (chk.sync_hit || chk.prefix_hit) begin
            store_nxt[fill_r[2:0]] = rx;
            fill_nxt               = fill_r + 4'd1;
            if (chk.sync_hit) begin
              state_nxt = S_HEADER;
            end
          end else if (rx == SYNC0) begin
            // The new byte alone can still open a sync word.
            store_nxt[0] = rx;
            fill_nxt     = 4'd1;
          end else begin
            fill_nxt = 4'd0;
          end
        end
      end
      S_HEADER: begin
        if (accept) begin
          if (fill_r != fill_t'(STORE_DEPTH)) begin
            store_nxt[fill_r[2:0]] = rx;
            fill_nxt               = fill_r + 4'd1;
          end else if (!hdr_ok) begin
            // Drop the first header byte and rescan the other eight for sync.
            for (int k = 0; k < STORE_DEPTH - 1; k++) begin
              store_nxt[k] = store_r[k + 1];
            end
            store_nxt[STORE_DEPTH - 1] = rx;
            fill_nxt  = fill_t'(STORE_DEPTH);
            state_nxt = S_RESCAN;
          end else begin
            fill_nxt = 4'd0;
            if (hdr_len == 16'd0) begin
              state_nxt = S_HUNT;
              if (hdr_match) begin
                out_valid_nxt = 1'b1;
                out_byte_nxt  = 8'd0;
                out_last_nxt  = 1'b1;
                out_empty_nxt = 1'b1;
              end
            end else begin
              rem_nxt   = hdr_len;
              state_nxt = hdr_match ? S_DELIVER : S_SKIP;
            end
          end
        end
      end
      S_DELIVER, S_SKIP: begin
        if (accept) begin
          rem_nxt = rem_r - 16'd1;
          if (rem_r == 16'd1) begin
            state_nxt = S_HUNT;
            fill_nxt  = 4'd0;
          end
          if (state_r == S_DELIVER) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = rx;
            out_last_nxt  = (rem_r == 16'd1);
            out_empty_nxt = 1'b0;
          end
        end
      end
      S_RESCAN: begin
        // One byte position per cycle: stop on a full sync word or a sync prefix
        // at the tail, otherwise drop the front byte and look again.
        if (chk.sync_hit) begin
          state_nxt = S_HEADER;
        end else if (chk.prefix_hit) begin
          state_nxt = S_HUNT;
        end else begin
          for (int k = 0; k < STORE_DEPTH - 1; k++) begin
            store_nxt[k] = store_r[k + 1];
          end
          fill_nxt = fill_r - 4'd1;
        end
      end
      default: begin
        state_nxt = S_HUNT;
        fill_nxt  = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_HUNT;
      fill_r      <= 4'd0;
      rem_r       <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    store_r     <= store_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

  // Configuration writes land directly in the registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_cmd_r <= 8'd0;
      exp_seq_r <= 16'd0;
      max_len_r <= RST_MAX_LEN;
      version_r <= RST_VERSION;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_CMD:     exp_cmd_r <= cfg_wdata[7:0];
        REG_SEQ:     exp_seq_r <= cfg_wdata;
        REG_MAX_LEN: max_len_r <= cfg_wdata;
        REG_VERSION: version_r <= cfg_wdata[7:0];
        default:     exp_cmd_r <= exp_cmd_r;
      endcase
    end
  end

  // The rescan sequencer owns the buffer, so no byte may enter while it runs.
  a_rescan_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESCAN) |-> !in_ch.ready)
    else $error("input accepted during header rescan");

  // The buffer never holds more than the stored part of a header.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= fill_t'(STORE_DEPTH))
    else $error("header fill beyond buffer depth");

  // While hunting, only a sync prefix of at most two bytes is kept.
  a_hunt_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HUNT) |-> (fill_r <= 4'd2))
    else $error("hunting with more than a sync prefix buffered");

  // Payload modes always have bytes left to consume.
  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DELIVER) || (state_r == S_SKIP)) |-> (rem_r != 16'd0))
    else $error("payload mode with no bytes remaining");

  // An empty-frame marker is always the last transaction of its frame.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_last_r && (out_byte_r == 8'd0)))
    else $error("empty-frame marker without last flag or with data");

endmodule

// ===== hdl/shdf_sync_cmp.sv =====
// Sync compare unit: checks the first three bytes of a buffer view against the sync word.
// Depends on shdf_pkg; shared by the hunting step and the rescan sequencer.
module shdf_sync_cmp (
  input  shdf_pkg::byte_t     b0,
  input  shdf_pkg::byte_t     b1,
  input  shdf_pkg::byte_t     b2,
  input  shdf_pkg::fill_t     fill,
  output shdf_pkg::sync_chk_t chk
);
  import shdf_pkg::*;

  logic m0, m1, m2;

  assign m0 = (b0 == SYNC0);
  assign m1 = (b1 == SYNC1);
  assign m2 = (b2 == SYNC2);

  always_comb begin
    chk.sync_hit   = (fill >= 4'd3) && m0 && m1 && m2;
    chk.prefix_hit = (fill == 4'd0) ||
                     ((fill == 4'd1) && m0) ||
                     ((fill == 4'd2) && m0 && m1);
  end

endmodule

// ===== tb/sv/sync_header_frame_deframer_core_tb.sv =====
// Self-checking testbench for sync_header_frame_deframer_core: a short table of directed bytes,
// then framed random traffic, checked against a byte-level model of the frame parser.
// Depends on shdf_pkg, shdf_rx_if, shdf_res_if and the deframer RTL.
module sync_header_frame_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import shdf_pkg::*;

  // One result transaction: a payload byte or an empty-frame marker.
  typedef struct packed {
    byte_t pbyte;
    logic  last;
    logic  empty_frame;
  } payload_res_t;

  // How a directed row is checked: by the model, as a known silent byte, or against a
  // result typed straight into the table.
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_SILENT,
    ROW_RESULT
  } row_kind_t;

  typedef struct packed {
    byte_t        rx;
    row_kind_t    kind;
    payload_res_t res;
  } stim_row_t;

  localparam int unsigned  DIRECTED_COUNT = 25;
  localparam int unsigned  PHASE_COUNT    = 6;
  localparam int           PHASE_ITEMS    = 170;
  localparam int           LONG_FRAME     = 300;
  localparam int           DRAIN_CYCLES   = 16;
  localparam int           WATCHDOG_LIMIT = 2000;
  localparam payload_res_t NO_RES         = '0;

  // The directed table runs with the reset register values: version 1, command 0,
  // sequence 0 and a 512-byte length limit.
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // A lone sync start is kept while hunting, then thrown away by a plain byte.
    '{8'h42, ROW_PREDICT, NO_RES},
    '{8'h00, ROW_PREDICT, NO_RES},
    // A header with a bad version that hides a second sync word at byte four.
    '{8'h42, ROW_SILENT, NO_RES},
    '{8'h43, ROW_SILENT, NO_RES},
    '{8'h32, ROW_SILENT, NO_RES},
    '{8'h07, ROW_SILENT, NO_RES},
    '{8'h42, ROW_SILENT, NO_RES},
    '{8'h43, ROW_SILENT, NO_RES},
    '{8'h32, ROW_SILENT, NO_RES},
    '{8'h01, ROW_SILENT, NO_RES},
    '{8'h00, ROW_SILENT, NO_RES},
    // The rescan kept the inner header; four more bytes complete an empty frame.
    '{8'h00, ROW_PREDICT, NO_RES},
    '{8'h00, ROW_PREDICT, NO_RES},
    '{8'h00, ROW_PREDICT, NO_RES},
    '{8'h00, ROW_RESULT, '{8'h00, 1'b1, 1'b1}},
    // A one-byte matching frame whose payload is all ones.
    '{8'h42, ROW_SILENT, NO_RES},
    '{8'h43, ROW_SILENT, NO_RES},
    '{8'h32, ROW_SILENT, NO_RES},
    '{8'h01, ROW_SILENT, NO_RES},
    '{8'h00, ROW_SILENT, NO_RES},
    '{8'h00, ROW_SILENT, NO_RES},
    '{8'h00, ROW_SILENT, NO_RES},
    '{8'h01, ROW_SILENT, NO_RES},
    '{8'h00, ROW_SILENT, NO_RES},
    '{8'hFF, ROW_RESULT, '{8'hFF, 1'b1, 1'b0}}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  shdf_rx_if  in_ch();
  shdf_res_if out_ch();

  sync_header_frame_deframer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Register values as the parser should see them.
  byte_t cfg_cmd;
  len_t  cfg_seq;
  len_t  cfg_max_len;
  byte_t cfg_version;

  // Parser state of the model: header buffer, fill level, mode and payload countdown.
  byte_t  hdr_buf [HDR_BYTES];
  int     hdr_fill;
  state_t parse_state;
  len_t   bytes_left;

  payload_res_t expected_payload_q[$];
  int           mismatches;
  int           rx_sent;
  int           quiet_cycles;

  // Handshake pacing, shared between the stimulus and the result sink.
  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles_req;

  // Checking tag of the byte now offered on the input channel.
  row_kind_t    rx_kind;
  payload_res_t rx_typed;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Drops the n oldest buffered header bytes.
  function automatic void hdr_drop(int n);
    if (n >= hdr_fill) begin
      hdr_fill = 0;
    end else begin
      for (int i = 0; i + n < hdr_fill; i++) begin
        hdr_buf[i] = hdr_buf[i + n];
      end
      hdr_fill = hdr_fill - n;
    end
  endfunction

  // Aligns the first full sync word in the buffer to the front. Without one, hunting goes
  // on and only a tail that could still start the sync word ("B" or "BC") is kept.
  function automatic void hdr_resync();
    int found;
    found = -1;
    for (int i = 0; i + 3 <= hdr_fill; i++) begin
      if (found < 0 && hdr_buf[i] == SYNC0 && hdr_buf[i + 1] == SYNC1 &&
          hdr_buf[i + 2] == SYNC2) begin
        found = i;
      end
    end
    if (found >= 0) begin
      hdr_drop(found);
      parse_state = S_HEADER;
    end else begin
      parse_state = S_HUNT;
      if (hdr_fill >= 2 && hdr_buf[hdr_fill - 2] == SYNC0 && hdr_buf[hdr_fill - 1] == SYNC1) begin
        hdr_drop(hdr_fill - 2);
      end else if (hdr_fill >= 1 && hdr_buf[hdr_fill - 1] == SYNC0) begin
        hdr_drop(hdr_fill - 1);
      end else begin
        hdr_fill = 0;
      end
    end
  endfunction

  // Feeds one received byte through the parser model. Returns 1 when the byte gives a
  // result transaction, which is placed in res.
  function automatic bit deframe_byte(input byte_t b, output payload_res_t res);
    len_t plen;
    len_t pseq;
    bit   hit;
    res = NO_RES;
    deframe_byte = 1'b0;
    if (parse_state == S_DELIVER || parse_state == S_SKIP) begin
      if (bytes_left != 0) begin
        bytes_left = bytes_left - 1'b1;
      end
      if (parse_state == S_DELIVER) begin
        res.pbyte = b;
        res.last = (bytes_left == 0);
        deframe_byte = 1'b1;
      end
      if (bytes_left == 0) begin
        parse_state = S_HUNT;
        hdr_fill = 0;
      end
    end else begin
      if (hdr_fill >= HDR_BYTES) begin
        hdr_fill = 0;
      end
      hdr_buf[hdr_fill] = b;
      hdr_fill++;
      if (parse_state == S_HUNT) begin
        hdr_resync();
      end else if (hdr_fill == HDR_BYTES) begin
        plen = {hdr_buf[8], hdr_buf[7]};
        if (hdr_buf[3] != cfg_version || plen > cfg_max_len) begin
          // A rejected header loses its first byte and the rest is rescanned at once.
          hdr_drop(1);
          hdr_resync();
        end else begin
          pseq = {hdr_buf[6], hdr_buf[5]};
          hit = (hdr_buf[4] == cfg_cmd) && (pseq == cfg_seq);
          hdr_fill = 0;
          if (plen == 0) begin
            parse_state = S_HUNT;
            if (hit) begin
              res = '{8'h00, 1'b1, 1'b1};
              deframe_byte = 1'b1;
            end
          end else begin
            bytes_left = plen;
            parse_state = hit ? S_DELIVER : S_SKIP;
          end
        end
      end
    end
  endfunction

  function automatic void log_mismatch(string what, payload_res_t want, payload_res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display(
        "%0t: %s: expected byte 0x%02h last %0b empty %0b, got byte 0x%02h last %0b empty %0b",
        $realtime, what, want.pbyte, want.last, want.empty_frame,
        got.pbyte, got.last, got.empty_frame);
    end
  endfunction

  // Payload filler that leans toward sync bytes, so that skipped frames and noise
  // carry false sync words.
  function automatic byte_t pick_byte();
    case ($urandom_range(7))
      0: return SYNC0;
      1: return SYNC1;
      2: return SYNC2;
      default: return byte_t'($urandom);
    endcase
  endfunction

  // Offers one byte on the input channel, after a random gap, and holds it until the
  // transaction completes. Called and returning at a falling edge; valid is left high so
  // that back-to-back bytes need no second assignment in the same time step.
  task automatic send_rx(input byte_t b, input row_kind_t kind = ROW_PREDICT,
                         input payload_res_t typed = NO_RES);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    rx_kind  = kind;
    rx_typed = typed;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    rx_sent++;
    @(negedge clk);
  endtask

  // Sends the first hdr_cut bytes of a frame header. A complete header is followed by its
  // payload unless the length is too large to be worth sending.
  task automatic send_frame(input byte_t ver, input byte_t cmd, input len_t seq,
                            input len_t len, input int hdr_cut);
    byte_t hdr [HDR_BYTES];
    hdr = '{SYNC0, SYNC1, SYNC2, ver, cmd, seq[7:0], seq[15:8], len[7:0], len[15:8]};
    for (int i = 0; i < hdr_cut; i++) begin
      send_rx(hdr[i]);
    end
    if (hdr_cut == HDR_BYTES && len <= LONG_FRAME) begin
      for (int i = 0; i < len; i++) begin
        send_rx(pick_byte());
      end
    end
  endtask

  // Writes all four registers on back-to-back cycles. Only called while the block is idle.
  task automatic write_regs(input byte_t cmd, input len_t seq, input len_t max_len,
                            input byte_t ver);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CMD;
    cfg_wdata <= {8'h00, cmd};
    @(negedge clk);
    cfg_index <= REG_SEQ;
    cfg_wdata <= seq;
    @(negedge clk);
    cfg_index <= REG_MAX_LEN;
    cfg_wdata <= max_len;
    @(negedge clk);
    cfg_index <= REG_VERSION;
    cfg_wdata <= {8'h00, ver};
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_cmd     = cmd;
    cfg_seq     = seq;
    cfg_max_len = max_len;
    cfg_version = ver;
  endtask

  // Result sink. The ready line is redrawn every falling edge; a long hold-off, when
  // requested, is counted down here while the stimulus keeps offering bytes.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_cycles_req != 0) begin
        hold_left = stall_cycles_req;
        stall_cycles_req = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Transaction monitor. Results are checked before the model sees the byte taken at the
  // same edge, since a byte never yields its result in the cycle it is accepted.
  always @(posedge clk) begin : monitor
    payload_res_t got;
    payload_res_t predicted;
    bit           produced;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.payload_byte, out_ch.last, out_ch.empty_frame};
        if (expected_payload_q.size() == 0) begin
          log_mismatch("result with none pending", NO_RES, got);
        end else if (expected_payload_q[0] !== got) begin
          log_mismatch("result mismatch", expected_payload_q.pop_front(), got);
        end else begin
          void'(expected_payload_q.pop_front());
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        // Typed rows still advance the model so that its state stays in step.
        produced = deframe_byte(in_ch.rx_byte, predicted);
        case (rx_kind)
          ROW_SILENT: ;
          ROW_RESULT: expected_payload_q.push_back(rx_typed);
          default: begin
            if (produced) begin
              expected_payload_q.push_back(predicted);
            end
          end
        endcase
      end
    end
  end

  // Watchdog: ends the run when no transaction has moved on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sync_header_frame_deframer_core regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int    phase_start;
    int    pick;
    int    r;
    int    flen;
    int    cut;
    int    nbytes;
    byte_t ver;
    byte_t cmd;
    len_t  seq;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_CMD;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.rx_byte    = '0;
    rx_kind          = ROW_PREDICT;
    rx_typed         = NO_RES;
    mismatches       = 0;
    rx_sent          = 0;
    quiet_cycles     = 0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    stall_cycles_req = 0;
    cfg_cmd          = 8'h00;
    cfg_seq          = 16'h0000;
    cfg_max_len      = RST_MAX_LEN;
    cfg_version      = RST_VERSION;
    hdr_fill         = 0;
    parse_state      = S_HUNT;
    bytes_left       = '0;
    foreach (hdr_buf[i]) begin
      hdr_buf[i] = 8'h00;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      // Pacing: a slow receiver first, then a slow sender, then full rate both ways.
      case (phase / 2)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      case (phase)
        0: begin
          for (int i = 0; i < DIRECTED_COUNT; i++) begin
            send_rx(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].res);
          end
        end
        1: begin
          // All registers at their top values, with one long matching frame.
          write_regs(8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
          send_frame(8'hFF, 8'hFF, 16'hFFFF, len_t'(LONG_FRAME), HDR_BYTES);
        end
        2: write_regs(8'h00, 16'h0000, 16'h0000, 8'h00);
        3: write_regs(byte_t'($urandom), len_t'($urandom), 16'd5, byte_t'($urandom));
        4: begin
          write_regs(byte_t'($urandom), len_t'($urandom), 16'd16, RST_VERSION);
          // Hold the result side off long enough for the input side to back up.
          stall_cycles_req = 300;
        end
        default: begin
          write_regs(byte_t'($urandom), len_t'($urandom), len_t'($urandom_range(40, 0)),
                     byte_t'($urandom));
        end
      endcase

      phase_start = rx_sent;
      while (rx_sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          // Well-formed frame; most headers pass and most frames match.
          ver = ($urandom_range(9) != 0) ? cfg_version : byte_t'($urandom);
          cmd = ($urandom_range(3) != 0) ? cfg_cmd : byte_t'($urandom);
          seq = ($urandom_range(3) != 0) ? cfg_seq : len_t'($urandom);
          r = $urandom_range(99);
          if (r < 15) begin
            flen = 0;
          end else if (r < 75) begin
            flen = $urandom_range(6, 1);
          end else if (r < 85) begin
            flen = $urandom_range(40, 7);
          end else if (r < 95 && cfg_max_len != 16'hFFFF) begin
            // Just over the limit, or anywhere above it.
            flen = ($urandom_range(1) != 0) ? cfg_max_len + 1
                                             : $urandom_range(65535, cfg_max_len + 1);
          end else begin
            flen = (cfg_max_len <= 40) ? cfg_max_len : $urandom_range(6, 1);
          end
          send_frame(ver, cmd, seq, len_t'(flen), HDR_BYTES);
        end else if (pick < 85) begin
          nbytes = $urandom_range(8, 1);
          repeat (nbytes) send_rx(pick_byte());
        end else begin
          // Truncated header. With a huge length limit only the sync word is cut, since a
          // cut further in would let the next frame supply a huge accepted length.
          cut = (cfg_max_len > 1000) ? $urandom_range(3, 1) : $urandom_range(8, 1);
          send_frame(cfg_version, cfg_cmd, cfg_seq, len_t'($urandom_range(6, 1)), cut);
        end
      end

      // Let every pending result out, then give a possible header rescan time to finish
      // before the registers change.
      in_ch.valid <= 1'b0;
      while (expected_payload_q.size() != 0) begin
        @(negedge clk);
      end
      repeat (DRAIN_CYCLES) @(negedge clk);
    end

    if (mismatches == 0 && expected_payload_q.size() == 0) begin
      $display("sync_header_frame_deframer_core regression: pass");
    end else begin
      $display("sync_header_frame_deframer_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/shdf_pkg.sv
hdl/shdf_rx_if.sv
hdl/shdf_res_if.sv
hdl/shdf_sync_cmp.sv
hdl/sync_header_frame_deframer_core.sv
tb/sv/sync_header_frame_deframer_core_tb.sv
